@@ hw/rtl/chs_pkg.sv @@
// Shared constants and the arctangent table for the cosine hemisphere sampler.
// Depends on nothing; the top level, chs_front and chs_back import it.
`timescale 1ns / 1ps
package chs_pkg;

  localparam int INPUT_BITS_DEF   = 16;
  localparam int OUT_FRAC_DEF     = 14;
  localparam int CORDIC_STEPS_DEF = 16;

  // Angle and rotator format: Q2.30 held in a 34-bit signed word.
  localparam int ANG_FRAC = 30;
  localparam int CORD_W   = 34;

  localparam logic [ANG_FRAC-1:0] PI_4_Q30 = 30'd843314857;
  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // atan(2^-i) in unsigned Q0.30, truncated except entry 0, which is rounded.
  function automatic logic [ANG_FRAC-1:0] atan_q30(input logic [4:0] i);
    logic [ANG_FRAC-1:0] v;
    unique case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd7;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/cosine_hemisphere_sampler_unit.sv @@
// Top level of the cosine-weighted hemisphere sampler.
// Depends on chs_pkg, chs_front, chs_queue and chs_back.
`timescale 1ns / 1ps
// Each beat in carries two uniform numbers u_first and u_second (unsigned
// Q0.INPUT_BITS) and yields exactly one beat out: a cosine-weighted direction
// dir_x, dir_y (signed Q1.OUTPUT_FRAC_BITS, within [-1,1]) and dir_z (unsigned,
// the floor of sqrt(1 - x^2 - y^2), zero at the rim). Offsets are 2u - 1; the
// larger magnitude picks the sector of the concentric disk mapping, the ratio of
// the two gives the angle, and a CORDIC supplies cos and sin. Both u equal to
// one half gives (0, 0, 1). Both sides behave as queues: push while full is low,
// pop while empty is low. As long as pop keeps up, a new beat is taken every
// cycle and results come out one per cycle. Between input and result lie the
// front register, the queue, the one-bit per stage ratio divider (31 stages),
// the angle scale, the CORDIC (one stage per step), the output scaling,
// rounding, squaring and radicand registers, the one-bit per stage square root
// and the result register. A front register and a two-entry queue keep taking
// input while a result waits; the back pipeline moves only when its result
// register is free or being popped.
module cosine_hemisphere_sampler_unit import chs_pkg::*; #(
  parameter int INPUT_BITS       = INPUT_BITS_DEF,
  parameter int OUTPUT_FRAC_BITS = OUT_FRAC_DEF,
  parameter int CORDIC_STEPS     = CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [INPUT_BITS-1:0]              u_first,
  input  logic [INPUT_BITS-1:0]              u_second,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [OUTPUT_FRAC_BITS+1:0] dir_x,
  output logic signed [OUTPUT_FRAC_BITS+1:0] dir_y,
  output logic [OUTPUT_FRAC_BITS:0]          dir_z
);

  localparam int FW = 2 * INPUT_BITS + 5;

  logic          q_push, q_full, q_nempty, q_pop;
  logic [FW-1:0] q_wdata, q_rdata;
  logic          out_valid, adv;

  // The whole back pipeline advances when the result register can take a beat.
  assign adv   = !out_valid || pop;
  assign q_pop = adv && q_nempty;
  assign empty = !out_valid;

  chs_front #(.INPUT_BITS(INPUT_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .u_first  (u_first),
    .u_second (u_second),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  chs_queue #(.WIDTH(FW)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .pop      (q_pop),
    .data_in  (q_wdata),
    .full     (q_full),
    .nempty   (q_nempty),
    .data_out (q_rdata)
  );

  chs_back #(
    .INPUT_BITS       (INPUT_BITS),
    .OUTPUT_FRAC_BITS (OUTPUT_FRAC_BITS),
    .CORDIC_STEPS     (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (q_nempty),
    .in_data   (q_rdata),
    .out_valid (out_valid),
    .dir_x     (dir_x),
    .dir_y     (dir_y),
    .dir_z     (dir_z)
  );

endmodule

@@ hw/rtl/chs_front.sv @@
// Front stage: maps the uniform pair to offsets, picks the sector and registers
// ratio operands and signs. Depends on chs_pkg.
`timescale 1ns / 1ps
module chs_front import chs_pkg::*; #(
  parameter int INPUT_BITS = INPUT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [INPUT_BITS-1:0]     u_first,
  input  logic [INPUT_BITS-1:0]     u_second,
  input  logic                      q_full,
  output logic                      q_push,
  output logic [2*INPUT_BITS+4:0]   q_data
);

  localparam int MW = INPUT_BITS + 1;
  localparam int OW = INPUT_BITS + 2;
  localparam int FW = 2 * MW + 3;

  logic signed [OW-1:0] ox, oy;
  logic [MW-1:0] ox_m, oy_m, num_m, den_m;
  logic first, num_neg, den_neg;
  logic f_valid, f_adv;
  logic [FW-1:0] f_data, f_data_next;

  assign ox = $signed({1'b0, u_first, 1'b0}) - $signed(OW'(1) << INPUT_BITS);
  assign oy = $signed({1'b0, u_second, 1'b0}) - $signed(OW'(1) << INPUT_BITS);
  assign ox_m = ox[OW-1] ? MW'(-ox) : ox[MW-1:0];
  assign oy_m = oy[OW-1] ? MW'(-oy) : oy[MW-1:0];

  always_comb begin
    first   = ox_m > oy_m;
    num_m   = first ? oy_m : ox_m;
    den_m   = first ? ox_m : oy_m;
    num_neg = first ? oy[OW-1] : ox[OW-1];
    den_neg = first ? ox[OW-1] : oy[OW-1];
    f_data_next = {first, den_neg, num_neg ^ den_neg, num_m, den_m};
  end

  assign f_adv  = !f_valid || !q_full;
  assign full   = !f_adv;
  assign q_push = f_valid && !q_full;
  assign q_data = f_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (f_adv) begin
      f_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (f_adv && push) begin
      f_data <= f_data_next;
    end
  end

endmodule

@@ hw/rtl/chs_queue.sv @@
// Two-entry queue that decouples the front stage from the back pipeline.
// Depends on nothing beyond its width parameter.
`timescale 1ns / 1ps
module chs_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             pop,
  input  logic [WIDTH-1:0] data_in,
  output logic             full,
  output logic             nempty,
  output logic [WIDTH-1:0] data_out
);

  logic [WIDTH-1:0] mem [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full     = count == 2'd2;
  assign nempty   = count != 2'd0;
  assign data_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= data_in;
    end
  end

endmodule

@@ hw/rtl/chs_back.sv @@
// Back pipeline: ratio divider, angle scale, CORDIC, output scaling, square root
// and the result register. Depends on chs_pkg.
`timescale 1ns / 1ps
module chs_back import chs_pkg::*; #(
  parameter int INPUT_BITS       = INPUT_BITS_DEF,
  parameter int OUTPUT_FRAC_BITS = OUT_FRAC_DEF,
  parameter int CORDIC_STEPS     = CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              in_valid,
  input  logic [2*INPUT_BITS+4:0]           in_data,
  output logic                              out_valid,
  output logic signed [OUTPUT_FRAC_BITS+1:0] dir_x,
  output logic signed [OUTPUT_FRAC_BITS+1:0] dir_y,
  output logic [OUTPUT_FRAC_BITS:0]          dir_z
);

  localparam int MW  = INPUT_BITS + 1;
  localparam int RW  = INPUT_BITS + 2;
  localparam int FW  = 2 * MW + 3;
  localparam int QW  = ANG_FRAC + 1;
  localparam int PRW = QW + ANG_FRAC;
  localparam int PW  = MW + CORD_W;
  localparam int SH  = INPUT_BITS + ANG_FRAC - OUTPUT_FRAC_BITS;
  localparam int XW  = OUTPUT_FRAC_BITS + 2;
  localparam int ZW  = OUTPUT_FRAC_BITS + 1;
  localparam int SW  = 2 * OUTPUT_FRAC_BITS + 2;
  localparam int DW  = 2 * XW + 1;
  localparam int LIM = 1 << OUTPUT_FRAC_BITS;

  typedef struct packed {
    logic          first;
    logic          r_neg;
    logic          ang_neg;
    logic [MW-1:0] r_m;
  } side_t;

  // Rounds a magnitude product to the output grid, saturates, applies the sign.
  function automatic logic signed [XW-1:0] round_sat(input logic [PW-1:0] p,
                                                     input logic neg);
    logic [PW:0] pr;
    logic [XW-1:0] m;
    pr = ({1'b0, p} + ((PW + 1)'(1) << (SH - 1))) >> SH;
    if (pr > (PW + 1)'(LIM)) m = XW'(LIM);
    else m = pr[XW-1:0];
    return neg ? -$signed(m) : $signed(m);
  endfunction

  side_t in_side;
  logic [MW-1:0] in_num;
  assign in_side = '{first: in_data[FW-1], r_neg: in_data[FW-2],
                     ang_neg: in_data[FW-3], r_m: in_data[MW-1:0]};
  assign in_num = in_data[2*MW-1:MW];

  // Restoring divider, one quotient bit per stage, most significant first.
  logic          dv_v   [QW];
  logic [RW-1:0] dv_rem [QW];
  logic [QW-1:0] dv_q   [QW];
  side_t         dv_s   [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [RW-1:0] rem_in, rem_new;
    logic [QW-1:0] q_in, q_new;
    side_t s_in;
    logic v_in, ge;
    if (j == 0) begin : g_first
      assign rem_in = RW'(in_num);
      assign q_in   = '0;
      assign s_in   = in_side;
      assign v_in   = in_valid;
    end else begin : g_next
      assign rem_in = dv_rem[j-1] << 1;
      assign q_in   = dv_q[j-1];
      assign s_in   = dv_s[j-1];
      assign v_in   = dv_v[j-1];
    end
    always_comb begin
      ge = rem_in >= RW'(s_in.r_m);
      rem_new = ge ? rem_in - RW'(s_in.r_m) : rem_in;
      q_new = q_in;
      q_new[QW-1-j] = ge;
    end
    always_ff @(posedge clk) begin
      if (rst) dv_v[j] <= 1'b0;
      else if (adv) dv_v[j] <= v_in;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[j] <= rem_new;
        dv_q[j]   <= q_new;
        dv_s[j]   <= s_in;
      end
    end
  end

  // Ratio times pi/4.
  logic           mp_v;
  logic [PRW-1:0] mp_prod;
  side_t          mp_s;

  always_ff @(posedge clk) begin
    if (rst) mp_v <= 1'b0;
    else if (adv) mp_v <= dv_v[QW-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      mp_prod <= PRW'(dv_q[QW-1]) * PRW'(PI_4_Q30);
      mp_s    <= dv_s[QW-1];
    end
  end

  logic signed [CORD_W-1:0] ang;
  always_comb begin
    ang = $signed(CORD_W'(mp_prod[ANG_FRAC +: ANG_FRAC]));
    if (mp_s.ang_neg) ang = -ang;
  end

  // CORDIC rotation, one micro-rotation per stage.
  logic                     cr_v [CORDIC_STEPS];
  logic signed [CORD_W-1:0] cr_x [CORDIC_STEPS];
  logic signed [CORD_W-1:0] cr_y [CORDIC_STEPS];
  logic signed [CORD_W-1:0] cr_z [CORDIC_STEPS];
  side_t                    cr_s [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CORD_W-1:0] x_in, y_in, z_in, dx, dy, at;
    side_t s_in;
    logic v_in;
    if (i == 0) begin : g_first
      assign x_in = CORDIC_GAIN;
      assign y_in = '0;
      assign z_in = ang;
      assign s_in = mp_s;
      assign v_in = mp_v;
    end else begin : g_next
      assign x_in = cr_x[i-1];
      assign y_in = cr_y[i-1];
      assign z_in = cr_z[i-1];
      assign s_in = cr_s[i-1];
      assign v_in = cr_v[i-1];
    end
    assign dx = y_in >>> i;
    assign dy = x_in >>> i;
    assign at = $signed(CORD_W'(atan_q30(5'(i))));
    always_ff @(posedge clk) begin
      if (rst) cr_v[i] <= 1'b0;
      else if (adv) cr_v[i] <= v_in;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cr_s[i] <= s_in;
        if (!z_in[CORD_W-1]) begin
          cr_x[i] <= x_in - dx;
          cr_y[i] <= y_in + dy;
          cr_z[i] <= z_in - at;
        end else begin
          cr_x[i] <= x_in + dx;
          cr_y[i] <= y_in - dy;
          cr_z[i] <= z_in + at;
        end
      end
    end
  end

  // Radius times cos and sin, as magnitudes.
  logic [CORD_W-1:0] c_m, s_m;
  logic              sc_v, sc_cn, sc_sn;
  logic [PW-1:0]     sc_pc, sc_ps;
  side_t             sc_s;

  assign c_m = cr_x[CORDIC_STEPS-1][CORD_W-1] ? CORD_W'(-cr_x[CORDIC_STEPS-1])
                                               : CORD_W'(cr_x[CORDIC_STEPS-1]);
  assign s_m = cr_y[CORDIC_STEPS-1][CORD_W-1] ? CORD_W'(-cr_y[CORDIC_STEPS-1])
                                               : CORD_W'(cr_y[CORDIC_STEPS-1]);

  always_ff @(posedge clk) begin
    if (rst) sc_v <= 1'b0;
    else if (adv) sc_v <= cr_v[CORDIC_STEPS-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sc_pc <= PW'(cr_s[CORDIC_STEPS-1].r_m) * PW'(c_m);
      sc_ps <= PW'(cr_s[CORDIC_STEPS-1].r_m) * PW'(s_m);
      sc_cn <= cr_x[CORDIC_STEPS-1][CORD_W-1];
      sc_sn <= cr_y[CORDIC_STEPS-1][CORD_W-1];
      sc_s  <= cr_s[CORDIC_STEPS-1];
    end
  end

  // Round, saturate and put the components back in sector order.
  logic signed [XW-1:0] rc, rs;
  logic                 rd_v;
  logic signed [XW-1:0] rd_x, rd_y;

  assign rc = round_sat(sc_pc, sc_s.r_neg ^ sc_cn);
  assign rs = round_sat(sc_ps, sc_s.r_neg ^ sc_sn);

  always_ff @(posedge clk) begin
    if (rst) rd_v <= 1'b0;
    else if (adv) rd_v <= sc_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_x <= sc_s.first ? rc : rs;
      rd_y <= sc_s.first ? rs : rc;
    end
  end

  // Squares of the final components.
  logic                 sq_v;
  logic [2*XW-1:0]      sq_xx, sq_yy;
  logic signed [XW-1:0] sq_x, sq_y;

  always_ff @(posedge clk) begin
    if (rst) sq_v <= 1'b0;
    else if (adv) sq_v <= rd_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_xx <= (2 * XW)'(rd_x * rd_x);
      sq_yy <= (2 * XW)'(rd_y * rd_y);
      sq_x  <= rd_x;
      sq_y  <= rd_y;
    end
  end

  // Radicand, clamped at zero.
  logic signed [DW-1:0] d;
  logic                 ds_v;
  logic [SW-1:0]        ds_rad;
  logic signed [XW-1:0] ds_x, ds_y;

  assign d = $signed(DW'(1) << (2 * OUTPUT_FRAC_BITS)) - $signed(DW'(sq_xx))
           - $signed(DW'(sq_yy));

  always_ff @(posedge clk) begin
    if (rst) ds_v <= 1'b0;
    else if (adv) ds_v <= sq_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ds_rad <= (d > 0) ? SW'(d) : '0;
      ds_x   <= sq_x;
      ds_y   <= sq_y;
    end
  end

  // Integer square root, one root bit per stage.
  logic                 sr_v    [ZW];
  logic [SW:0]          sr_rem  [ZW];
  logic [ZW-1:0]        sr_root [ZW];
  logic signed [XW-1:0] sr_x    [ZW];
  logic signed [XW-1:0] sr_y    [ZW];

  for (genvar j = 0; j < ZW; j++) begin : g_sqrt
    localparam int K = ZW - 1 - j;
    logic [SW:0] rem_in, trial;
    logic [ZW-1:0] root_in;
    logic signed [XW-1:0] x_in, y_in;
    logic v_in;
    if (j == 0) begin : g_first
      assign rem_in  = (SW + 1)'(ds_rad);
      assign root_in = '0;
      assign x_in    = ds_x;
      assign y_in    = ds_y;
      assign v_in    = ds_v;
    end else begin : g_next
      assign rem_in  = sr_rem[j-1];
      assign root_in = sr_root[j-1];
      assign x_in    = sr_x[j-1];
      assign y_in    = sr_y[j-1];
      assign v_in    = sr_v[j-1];
    end
    assign trial = ((SW + 1)'(root_in) << (K + 1)) + ((SW + 1)'(1) << (2 * K));
    always_ff @(posedge clk) begin
      if (rst) sr_v[j] <= 1'b0;
      else if (adv) sr_v[j] <= v_in;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sr_x[j] <= x_in;
        sr_y[j] <= y_in;
        if (rem_in >= trial) begin
          sr_rem[j]  <= rem_in - trial;
          sr_root[j] <= root_in | (ZW'(1) << K);
        end else begin
          sr_rem[j]  <= rem_in;
          sr_root[j] <= root_in;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= sr_v[ZW-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dir_x <= sr_x[ZW-1];
      dir_y <= sr_y[ZW-1];
      dir_z <= sr_root[ZW-1];
    end
  end

endmodule

@@ hw/rtl/chs_check.sv @@
// Port-level checker for the sampler and the bind that attaches it.
// Depends on cosine_hemisphere_sampler_unit.
`timescale 1ns / 1ps
module chs_check #(
  parameter int OUTPUT_FRAC_BITS = 14
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               empty,
  input logic                               pop,
  input logic signed [OUTPUT_FRAC_BITS+1:0] dir_x,
  input logic signed [OUTPUT_FRAC_BITS+1:0] dir_y,
  input logic [OUTPUT_FRAC_BITS:0]          dir_z
);

  localparam int XW = OUTPUT_FRAC_BITS + 2;
  localparam logic signed [XW-1:0] POS = XW'(1) << OUTPUT_FRAC_BITS;
  localparam logic signed [XW-1:0] NEG = -POS;
  localparam logic [XW-2:0] ONE_Z = (XW - 1)'(1) << OUTPUT_FRAC_BITS;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result visible right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(dir_x) && $stable(dir_y) && $stable(dir_z))
    else $error("waiting result changed or vanished");

  a_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> dir_x <= POS && dir_x >= NEG && dir_y <= POS && dir_y >= NEG
               && dir_z <= ONE_Z)
    else $error("direction component out of range");

  a_pole: assert property (@(posedge clk) disable iff (rst)
    !empty && dir_x == '0 && dir_y == '0 |-> dir_z == ONE_Z)
    else $error("zero disk point must give the pole");

endmodule

bind cosine_hemisphere_sampler_unit chs_check #(
  .OUTPUT_FRAC_BITS (OUTPUT_FRAC_BITS)
) u_chs_check (
  .clk   (clk),
  .rst   (rst),
  .empty (empty),
  .pop   (pop),
  .dir_x (dir_x),
  .dir_y (dir_y),
  .dir_z (dir_z)
);
